[design/radix_string_converter_core_macros.svh]
// assertion macros shared by the radix converter checker
`ifndef RADIX_STRING_CONVERTER_CORE_MACROS_SVH
`define RADIX_STRING_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define RSC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsc check failed");

// next-cycle implication, clocked on clk, off during reset
`define RSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsc check failed");

`endif

[design/rsc_pkg.sv]
// shared types, constants and helper functions of the radix string converter
`default_nettype none

package rsc_pkg;

    localparam int MAX_SYMBOLS   = 16;
    localparam int DIV_STEP_BITS = 8;
    localparam int DIGIT_BITS    = 4;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_FROM_LOW  = 3'd0;
    localparam cfg_index_t CFG_FROM_HIGH = 3'd1;
    localparam cfg_index_t CFG_FROM_CNT  = 3'd2;
    localparam cfg_index_t CFG_TO_LOW    = 3'd3;
    localparam cfg_index_t CFG_TO_HIGH   = 3'd4;
    localparam cfg_index_t CFG_TO_CNT    = 3'd5;

    typedef struct packed {
        logic [7:0] symbol;
        logic       final_char;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       run_end;
        logic       bad_alphabet;
    } out_word_t;

    typedef struct packed {
        logic [63:0] from_low;
        logic [63:0] from_high;
        logic [4:0]  from_count;
        logic [63:0] to_low;
        logic [63:0] to_high;
        logic [4:0]  to_count;
    } cfg_t;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGIT,
        PH_STOP
    } parse_phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ERROR,
        BK_SIGN,
        BK_DIVIDE,
        BK_READ,
        BK_EMIT
    } back_state_t;

    // symbol count limited to the alphabet size
    function automatic logic [4:0] clamp_count(input logic [4:0] c);
        return (c > 5'(MAX_SYMBOLS)) ? 5'(MAX_SYMBOLS) : c;
    endfunction

    // byte i of a 16-symbol alphabet held in two 64-bit words
    function automatic logic [7:0] sym_at(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [3:0] i);
        logic [127:0] w;
        w = {hi, lo};
        return w[{i, 3'b000} +: 8];
    endfunction

    // tab through carriage return, and space
    function automatic logic is_space(input logic [7:0] c);
        return c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
    endfunction

endpackage

`default_nettype wire

[design/rsc_front.sv]
// front end: parses characters and hands finished numbers to the queue
`default_nettype none

module rsc_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rsc_pkg::cfg_t     cfg,
    input  logic              char_valid,
    output logic              char_ready,
    input  rsc_pkg::in_word_t char_word,
    input  logic              q_full,
    output logic              q_push,
    output logic [VALUE_BITS:0] q_data
);
    import rsc_pkg::*;

    parse_phase_t            phase_reg, phase_next;
    logic                    neg_reg, neg_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;

    logic                    accept;
    logic [4:0]              n_from;
    logic                    hit;
    logic [3:0]              idx;
    logic                    c_space, c_minus, c_plus;
    logic                    go_sign, go_digit, take_sign, take_digit;
    logic [VALUE_BITS-1:0]   prod;
    logic [VALUE_BITS-1:0]   acc_sum;
    logic                    neg_cur;
    logic [VALUE_BITS-1:0]   acc_cur;

    assign char_ready = !q_full;
    assign accept     = char_valid && char_ready;

    // first matching source symbol
    always_comb
    begin
        n_from = clamp_count(cfg.from_count);
        hit    = 1'b0;
        idx    = 4'd0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--)
        begin
            if ((5'(i) < n_from) &&
                (sym_at(cfg.from_low, cfg.from_high, 4'(i)) == char_word.symbol))
            begin
                hit = 1'b1;
                idx = 4'(i);
            end
        end
    end

    // character classes and phase walk-through
    assign c_space    = is_space(char_word.symbol);
    assign c_minus    = (char_word.symbol == CHAR_MINUS);
    assign c_plus     = (char_word.symbol == CHAR_PLUS);
    assign go_sign    = ((phase_reg == PH_SPACE) && !c_space) || (phase_reg == PH_SIGN);
    assign take_sign  = go_sign && (c_minus || c_plus);
    assign go_digit   = (go_sign && !c_minus && !c_plus) || (phase_reg == PH_DIGIT);
    assign take_digit = go_digit && hit;

    // accumulate with the raw source count as multiplier
    assign prod    = acc_reg * VALUE_BITS'(cfg.from_count);
    assign acc_sum = prod + VALUE_BITS'(idx);
    assign neg_cur = neg_reg ^ (take_sign && c_minus);
    assign acc_cur = take_digit ? acc_sum : acc_reg;

    // next parse phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (char_word.final_char)
                phase_next = PH_SPACE;
            else if (take_sign)
                phase_next = PH_SIGN;
            else if (take_digit)
                phase_next = PH_DIGIT;
            else if (go_digit)
                phase_next = PH_STOP;
        end
    end

    // value, sign and queue push
    always_comb
    begin
        neg_next = neg_reg;
        acc_next = acc_reg;
        q_push   = 1'b0;
        q_data   = {neg_cur, acc_cur};
        if (accept)
        begin
            if (char_word.final_char)
            begin
                q_push   = 1'b1;
                neg_next = 1'b0;
                acc_next = '0;
            end
            else
            begin
                neg_next = neg_cur;
                acc_next = acc_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

`default_nettype wire

[design/rsc_queue.sv]
// short queue of parsed numbers between front and back end
`default_nettype none

module rsc_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);

    // depth is a power of two so the pointers wrap on their own
    logic [WIDTH-1:0] entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop && !empty)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if ((push && !full) && !(pop && !empty))
            count_next = count_reg + 1'b1;
        else if (!(push && !full) && (pop && !empty))
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            entries[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

[design/rsc_back.sv]
// back end: sign, digit division by the target radix and symbol output
`default_nettype none

module rsc_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rsc_pkg::cfg_t      cfg,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic [VALUE_BITS:0] q_data,
    output logic               result_valid,
    input  logic               result_ready,
    output rsc_pkg::out_word_t result_word
);
    import rsc_pkg::*;

    localparam int STEPS    = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int PAD_BITS = STEPS * DIV_STEP_BITS;
    localparam int STEP_W   = $clog2(STEPS + 1);
    localparam int IDX_W    = $clog2(VALUE_BITS);
    localparam int CNT_W    = $clog2(VALUE_BITS + 1);

    back_state_t            state_reg, state_next;
    logic                   tvalid_reg, tvalid_next;
    logic [4:0]             radix_reg;
    logic [PAD_BITS-1:0]    div_reg, div_next;
    logic [DIGIT_BITS-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       cnt_m1;
    logic [DIGIT_BITS-1:0]  rd_data_reg;
    logic                   out_valid_reg;
    out_word_t              out_word_reg;
    logic [DIGIT_BITS-1:0]  digit_store [VALUE_BITS];

    logic [7:0]             to_syms [MAX_SYMBOLS];
    logic [4:0]             n_to;
    logic [VALUE_BITS-1:0]  job_acc, neg_acc, signed_v, mag;
    logic                   job_neg, job_sign;
    logic [DIV_STEP_BITS-1:0] q_bits;
    logic [4:0]             trial;
    logic [DIGIT_BITS-1:0]  rem_step;
    logic [PAD_BITS-1:0]    quot_step;
    logic                   last_step;
    logic                   slot_free;
    logic                   load;
    logic                   mem_we;
    out_word_t              word;

    // target alphabet check, registered
    always_comb
    begin
        n_to = clamp_count(cfg.to_count);
        for (int i = 0; i < MAX_SYMBOLS; i++)
            to_syms[i] = sym_at(cfg.to_low, cfg.to_high, 4'(i));
        tvalid_next = (n_to >= 5'd2);
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (5'(i) < n_to)
            begin
                if (to_syms[i] inside {CHAR_SPACE, CHAR_PLUS, CHAR_MINUS})
                    tvalid_next = 1'b0;
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if ((5'(j) < n_to) && (to_syms[j] == to_syms[i]))
                        tvalid_next = 1'b0;
                end
            end
        end
    end

    // magnitude of the queued value
    assign job_acc  = q_data[VALUE_BITS-1:0];
    assign job_neg  = q_data[VALUE_BITS];
    assign neg_acc  = '0 - job_acc;
    assign signed_v = job_neg ? neg_acc : job_acc;
    assign job_sign = signed_v[VALUE_BITS-1];
    assign mag      = (job_sign ^ job_neg) ? neg_acc : job_acc;

    // one byte of restoring division per cycle
    always_comb
    begin
        rem_step = rem_reg;
        q_bits   = '0;
        trial    = '0;
        for (int k = DIV_STEP_BITS - 1; k >= 0; k--)
        begin
            trial = {rem_step, div_reg[PAD_BITS - DIV_STEP_BITS + k]};
            if (trial >= radix_reg)
            begin
                trial     = trial - radix_reg;
                q_bits[k] = 1'b1;
            end
            rem_step = trial[DIGIT_BITS-1:0];
        end
        quot_step = (div_reg << DIV_STEP_BITS) | PAD_BITS'(q_bits);
    end

    assign last_step = (step_reg == STEP_W'(STEPS - 1));
    assign slot_free = !out_valid_reg || result_ready;
    assign cnt_m1    = cnt_reg - 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (!tvalid_reg)
                        state_next = BK_ERROR;
                    else if (job_sign)
                        state_next = BK_SIGN;
                    else
                        state_next = BK_DIVIDE;
                end
            end
            BK_ERROR:
            begin
                if (slot_free)
                    state_next = BK_IDLE;
            end
            BK_SIGN:
            begin
                if (slot_free)
                    state_next = BK_DIVIDE;
            end
            BK_DIVIDE:
            begin
                if (last_step && (quot_step == '0))
                    state_next = BK_READ;
            end
            BK_READ:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (slot_free)
                    state_next = (cnt_reg == CNT_W'(1)) ? BK_IDLE : BK_READ;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath controls and result word
    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        load      = 1'b0;
        word      = '0;
        div_next  = div_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        cnt_next  = cnt_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    div_next  = PAD_BITS'(mag);
                    rem_next  = '0;
                    step_next = '0;
                    cnt_next  = '0;
                end
            end
            BK_ERROR:
            begin
                load = slot_free;
                word = '{out_symbol: CHAR_NUL, run_end: 1'b1, bad_alphabet: 1'b1};
            end
            BK_SIGN:
            begin
                load = slot_free;
                word = '{out_symbol: CHAR_MINUS, run_end: 1'b0, bad_alphabet: 1'b0};
            end
            BK_DIVIDE:
            begin
                div_next = quot_step;
                if (last_step)
                begin
                    mem_we    = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    step_next = '0;
                    rem_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                    rem_next  = rem_step;
                end
            end
            BK_READ:
            begin
                load = 1'b0;
            end
            BK_EMIT:
            begin
                load = slot_free;
                word = '{out_symbol: sym_at(cfg.to_low, cfg.to_high, rd_data_reg),
                         run_end: (cnt_reg == CNT_W'(1)), bad_alphabet: 1'b0};
                if (slot_free)
                    cnt_next = cnt_m1;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            tvalid_reg    <= 1'b0;
            radix_reg     <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tvalid_reg    <= tvalid_next;
            radix_reg     <= n_to;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= load || (out_valid_reg && !result_ready);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        if (load)
            out_word_reg <= word;
    end

    // digit store, least significant digit at entry zero
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_store[cnt_reg[IDX_W-1:0]] <= rem_step;
        rd_data_reg <= digit_store[cnt_m1[IDX_W-1:0]];
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

`default_nettype wire

[design/radix_string_converter_core.sv]
// top level of the radix string converter: config registers, front, queue, back
// Non-final characters are taken one per cycle while the queue is not full;
// the parser has no stall of its own. For a final character the shared
// byte-wide divider yields each output digit into the digit store, and the
// digits are then read out. A bad target alphabet gives a single error word instead.
// Reset clears config, parse state, queue and output; the digit store is not cleared.
`default_nettype none

module radix_string_converter_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_ready,
    input  rsc_pkg::in_word_t   char_word,
    output logic                result_valid,
    input  logic                result_ready,
    output rsc_pkg::out_word_t  result_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  rsc_pkg::cfg_index_t cfg_index,
    input  logic [63:0]         cfg_data
);
    import rsc_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    logic                  q_push, q_pop, q_full, q_empty;
    logic [VALUE_BITS:0]   q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    // configuration register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FROM_LOW:  cfg_next.from_low   = cfg_data;
                CFG_FROM_HIGH: cfg_next.from_high  = cfg_data;
                CFG_FROM_CNT:  cfg_next.from_count = cfg_data[4:0];
                CFG_TO_LOW:    cfg_next.to_low     = cfg_data;
                CFG_TO_HIGH:   cfg_next.to_high    = cfg_data;
                CFG_TO_CNT:    cfg_next.to_count   = cfg_data[4:0];
                default:       cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // parser
    rsc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_word  (char_word),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    // parsed number queue
    rsc_queue #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // converter and output stage
    rsc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_data       (q_rdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

endmodule

`default_nettype wire

[design/rsc_checker.sv]
// port-level checks of the radix string converter and their bind
`default_nettype none

`include "radix_string_converter_core_macros.svh"

module rsc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire rsc_pkg::out_word_t result_word
);
    import rsc_pkg::*;

    // a stalled result word holds
    `RSC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_word))

    // the error word is alone and carries a null symbol
    `RSC_ASSERT_IMPLY(a_error_word, result_valid && result_word.bad_alphabet, result_word.run_end && (result_word.out_symbol == CHAR_NUL))

    // a minus sign is always followed by digits
    `RSC_ASSERT_IMPLY(a_sign_not_last, result_valid && !result_word.bad_alphabet && (result_word.out_symbol == CHAR_MINUS), !result_word.run_end)

    // a valid target alphabet never yields space or plus
    `RSC_ASSERT_IMPLY(a_no_reserved, result_valid && !result_word.bad_alphabet, (result_word.out_symbol != CHAR_SPACE) && (result_word.out_symbol != CHAR_PLUS))

endmodule

bind radix_string_converter_core rsc_checker u_rsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
);

`default_nettype wire
